// ===== design/rm_pkg.sv =====
// Shared types and constants for the running median block.
// No dependencies; used by rm_cell, rm_or_tree and running_median.
package rm_pkg;

	localparam int SAMPLE_W  = 32;
	localparam int MEDIAN_W  = 33;
	localparam int COUNT_W   = 9;
	localparam int OUT_TDATA_W = 48;   // median + count, padded to bytes
	localparam int FAN_LOG2  = 4;      // OR tree fan-in of 16 per level
	localparam int PICK_W    = 2 * SAMPLE_W;

	// insert command broadcast to every cell
	typedef struct packed {
		logic                       en;
		logic signed [SAMPLE_W-1:0] x;
	} rm_ins_t;

endpackage

// ===== design/running_median.sv =====
// Running median top level: cell chain, OR read tree and stream handshakes.
// Depends on rm_pkg, rm_cell and rm_or_tree.
// Usage:
//   Input channel s_*: one item per signed 32-bit sample in s_tdata, s_tuser
//   set clears the held samples before this sample goes in. Output channel
//   m_*: one item per input item with twice the median (33-bit signed, one
//   fractional bit), the held count and, in m_tuser, a flag that the sample
//   was dropped because all CAPACITY slots were taken (old median repeated).
// Timing:
//   The sample is inserted by all cells in parallel at the accept edge.
//   The two middle slots are then picked out through a registered OR tree of
//   fan-in 16, LEVELS = ceil(log16(CAPACITY)) stages (2 at 256), and summed
//   into the output register once the tree top has settled and that
//   register is free, raising m_tvalid. A new item is taken only once the
//   previous result has been loaded into the output register.
// Stalls and reset:
//   The output register holds while m_tready is low; the block still takes
//   the next item and finishes it up to the output register, then waits.
//   arst_n empties the store and drops any pending result; slot contents
//   are not cleared, slots beyond the count are never read.
module running_median #(
	parameter int CAPACITY = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rm_pkg::SAMPLE_W-1:0]       s_tdata,   // [31:0] sample
	input  logic                              s_tuser,   // [0] start_req
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rm_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [32:0] median_doubled,
	                                                     // [41:33] count, [47:42] zero
	output logic                              m_tuser    // [0] full_res
);

	localparam int CW     = $clog2(CAPACITY + 1);
	localparam int LEVELS = ($clog2(CAPACITY) + rm_pkg::FAN_LOG2 - 1) / rm_pkg::FAN_LOG2;
	localparam int WW     = $clog2(LEVELS + 1);

	logic                  busy_q;
	logic [WW-1:0]         wait_q;
	logic [CW-1:0]         cnt_q;
	logic                  full_q;
	logic                  m_valid_q;
	logic [rm_pkg::MEDIAN_W-1:0] median_q;
	logic [rm_pkg::COUNT_W-1:0]  count_q;
	logic                  full_out_q;

	logic                  acc;
	logic [CW-1:0]         cnt_eff;
	logic                  full;
	logic                  load;
	logic [CW-1:0]         hi_idx;
	logic [CW-1:0]         lo_idx;
	rm_pkg::rm_ins_t       ins;

	logic signed [rm_pkg::SAMPLE_W-1:0] vals [CAPACITY];
	logic                               gts  [CAPACITY];
	logic [rm_pkg::PICK_W-1:0]          picks [CAPACITY];
	logic [rm_pkg::PICK_W-1:0]          top;
	logic signed [rm_pkg::SAMPLE_W-1:0] mid_hi;
	logic signed [rm_pkg::SAMPLE_W-1:0] mid_lo;

	// one item in flight; the next is taken once its result is registered
	assign s_tready = !busy_q;
	assign acc      = s_tvalid && s_tready;

	assign cnt_eff = s_tuser ? '0 : cnt_q;
	assign full    = cnt_eff == CW'(CAPACITY);
	assign ins.en  = acc && !full;
	assign ins.x   = s_tdata;

	// middle positions of the store after the insert
	assign hi_idx = cnt_q >> 1;
	assign lo_idx = (cnt_q - CW'(1)) >> 1;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_head
			rm_cell #(.IDX(i), .CW(CW)) u_cell (
				.clk      (clk),
				.ins      (ins),
				.cnt      (cnt_eff),
				.prev_val (ins.x),
				.prev_gt  (1'b0),
				.hi_idx   (hi_idx),
				.lo_idx   (lo_idx),
				.val      (vals[i]),
				.gt       (gts[i]),
				.pick     (picks[i])
			);
		end else begin : g_body
			rm_cell #(.IDX(i), .CW(CW)) u_cell (
				.clk      (clk),
				.ins      (ins),
				.cnt      (cnt_eff),
				.prev_val (vals[i-1]),
				.prev_gt  (gts[i-1]),
				.hi_idx   (hi_idx),
				.lo_idx   (lo_idx),
				.val      (vals[i]),
				.gt       (gts[i]),
				.pick     (picks[i])
			);
		end
	end

	rm_or_tree #(.N(CAPACITY), .W(rm_pkg::PICK_W)) u_tree (
		.clk  (clk),
		.leaf (picks),
		.top  (top)
	);

	assign mid_hi = top[rm_pkg::PICK_W-1:rm_pkg::SAMPLE_W];
	assign mid_lo = top[rm_pkg::SAMPLE_W-1:0];

	// load once the tree top has settled and the output register is free
	assign load = busy_q && (wait_q == WW'(LEVELS)) && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			wait_q    <= '0;
			cnt_q     <= '0;
			full_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				busy_q <= 1'b1;
				wait_q <= '0;
				cnt_q  <= full ? cnt_eff : cnt_eff + CW'(1);
				full_q <= full;
			end else if (busy_q && wait_q != WW'(LEVELS)) begin
				wait_q <= wait_q + WW'(1);
			end
			if (load) begin
				busy_q    <= 1'b0;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			median_q   <= {mid_hi[rm_pkg::SAMPLE_W-1], mid_hi}
			            + {mid_lo[rm_pkg::SAMPLE_W-1], mid_lo};
			count_q    <= rm_pkg::COUNT_W'({{rm_pkg::COUNT_W{1'b0}}, cnt_q});
			full_out_q <= full_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(rm_pkg::OUT_TDATA_W - rm_pkg::MEDIAN_W - rm_pkg::COUNT_W){1'b0}},
	                   count_q, median_q};
	assign m_tuser  = full_out_q;

endmodule

// ===== design/rm_cell.sv =====
// One slot of the sorted chain: holds one sample and shifts it up on insert.
// Depends on rm_pkg.
module rm_cell #(
	parameter int IDX = 0,
	parameter int CW  = 9
) (
	input  logic                                clk,
	input  rm_pkg::rm_ins_t                     ins,
	input  logic [CW-1:0]                       cnt,      // held count before insert
	input  logic signed [rm_pkg::SAMPLE_W-1:0]  prev_val,
	input  logic                                prev_gt,
	input  logic [CW-1:0]                       hi_idx,
	input  logic [CW-1:0]                       lo_idx,
	output logic signed [rm_pkg::SAMPLE_W-1:0]  val,
	output logic                                gt,
	output logic [rm_pkg::PICK_W-1:0]           pick      // {hi, lo} masked
);

	logic signed [rm_pkg::SAMPLE_W-1:0] val_q;
	logic in_use;
	logic at_end;

	assign in_use = CW'(IDX) < cnt;
	assign at_end = CW'(IDX) == cnt;
	assign gt     = in_use && (val_q > ins.x);
	assign val    = val_q;

	// neighbor below is larger than x: take its value; first larger slot, or the first free one, takes x
	always_ff @(posedge clk) begin
		if (ins.en) begin
			if (prev_gt) begin
				val_q <= prev_val;
			end else if (gt || at_end) begin
				val_q <= ins.x;
			end
		end
	end

	assign pick[rm_pkg::PICK_W-1:rm_pkg::SAMPLE_W] =
		(CW'(IDX) == hi_idx) ? val_q : '0;
	assign pick[rm_pkg::SAMPLE_W-1:0] =
		(CW'(IDX) == lo_idx) ? val_q : '0;

endmodule

// ===== design/rm_or_tree.sv =====
// Registered OR reduction tree, fan-in 16 per level, one register per level.
// Depends on rm_pkg.
module rm_or_tree #(
	parameter int N = 256,
	parameter int W = 64
) (
	input  logic         clk,
	input  logic [W-1:0] leaf [N],
	output logic [W-1:0] top
);

	localparam int FAN    = 1 << rm_pkg::FAN_LOG2;
	localparam int LEVELS = ($clog2(N) + rm_pkg::FAN_LOG2 - 1) / rm_pkg::FAN_LOG2;
	localparam int PADN   = 1 << (rm_pkg::FAN_LOG2 * LEVELS);

	function automatic int lvl_off(input int l);
		int s;
		s = 0;
		for (int j = 1; j < l; j++) begin
			s += PADN >> (rm_pkg::FAN_LOG2 * j);
		end
		return s;
	endfunction

	localparam int TOTAL = lvl_off(LEVELS + 1);

	logic [W-1:0] leaf_pad [PADN];
	logic [W-1:0] node_q [TOTAL];

	for (genvar i = 0; i < PADN; i++) begin : g_pad
		if (i < N) begin : g_real
			assign leaf_pad[i] = leaf[i];
		end else begin : g_zero
			assign leaf_pad[i] = '0;
		end
	end

	for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
		for (genvar k = 0; k < (PADN >> (rm_pkg::FAN_LOG2 * l)); k++) begin : g_node
			logic [W-1:0] acc;
			if (l == 1) begin : g_first
				always_comb begin
					acc = '0;
					for (int j = 0; j < FAN; j++) begin
						acc |= leaf_pad[FAN * k + j];
					end
				end
			end else begin : g_upper
				always_comb begin
					acc = '0;
					for (int j = 0; j < FAN; j++) begin
						acc |= node_q[lvl_off(l - 1) + FAN * k + j];
					end
				end
			end
			always_ff @(posedge clk) begin
				node_q[lvl_off(l) + k] <= acc;
			end
		end
	end

	assign top = node_q[lvl_off(LEVELS)];

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for running_median: sends signed samples with start flags, predicts
// twice the running median, held count and full flag, and checks every result.
// Depends on rm_pkg and running_median.
module testbench;

	localparam int SAMPLE_W    = rm_pkg::SAMPLE_W;
	localparam int MEDIAN_W    = rm_pkg::MEDIAN_W;
	localparam int COUNT_W     = rm_pkg::COUNT_W;
	localparam int OUT_TDATA_W = rm_pkg::OUT_TDATA_W;

	localparam int STORE_DEPTH = 256;
	localparam int HOLD_CYCLES = 300;      // long receiver hold-off
	localparam int DRAIN_CYCLES = 12;      // wait after the last result to catch stray ones
	localparam int CYCLE_LIMIT = 200000;

	localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;
	localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7fff_ffff;

	typedef enum int {VALUES_WIDE, VALUES_NARROW, VALUES_EDGE} value_mix_t;

	typedef struct {
		logic signed [MEDIAN_W-1:0] median2;
		logic [COUNT_W-1:0]         held;
		logic                       dropped;
	} median_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [SAMPLE_W-1:0]    s_tdata = '0;       // [31:0] sample
	logic                   s_tuser = 1'b0;     // [0] start_req
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;            // [32:0] median_doubled, [41:33] count
	logic                   m_tuser;            // [0] full_res

	// model of the sorted store
	logic signed [SAMPLE_W-1:0] sorted_vals [STORE_DEPTH];
	int unsigned                held_n = 0;
	median_result_t             pending_medians [$];

	int errors = 0;
	int cycle_count = 0;
	int sender_idle_pct = 22;
	int sink_idle_pct = 22;
	int stall_asks = 0;
	int stall_seen = 0;
	int stall_left = 0;

	running_median #(.CAPACITY(STORE_DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_medians.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// sorted insert, then twice the median of what is held
	function automatic median_result_t insert_sample(logic signed [SAMPLE_W-1:0] x,
		bit clear);
		median_result_t r;
		int unsigned pos;
		longint sum;
		if (clear)
			held_n = 0;
		r.dropped = 1'b0;
		if (held_n >= STORE_DEPTH) begin
			r.dropped = 1'b1;
		end else begin
			// equal values stay behind older ones
			pos = held_n;
			while (pos > 0 && sorted_vals[pos-1] > x) begin
				sorted_vals[pos] = sorted_vals[pos-1];
				pos--;
			end
			sorted_vals[pos] = x;
			held_n++;
		end
		if (held_n == 0)
			sum = 0;
		else if (held_n % 2 == 1)
			sum = 2 * longint'(sorted_vals[held_n/2]);
		else
			sum = longint'(sorted_vals[held_n/2]) + longint'(sorted_vals[held_n/2 - 1]);
		r.median2 = sum[MEDIAN_W-1:0];
		r.held = held_n[COUNT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("[%0d] mismatch %s: got %0d expected %0d", cycle_count, what, got, want);
		errors++;
	endtask

	// one item: optional gap, offer, wait for the handshake, record the expectation
	task automatic send_sample(logic signed [SAMPLE_W-1:0] x, bit clear);
		median_result_t expected;
		@(negedge clk);
		if ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= $urandom;
			s_tuser <= 1'($urandom_range(1));
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= x;
		s_tuser <= clear;
		do
			@(posedge clk);
		while (!s_tready);
		expected = insert_sample(x, clear);
		pending_medians.insert(pending_medians.size(), expected);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample(value_mix_t mix);
		logic signed [SAMPLE_W-1:0] v;
		case (mix)
			VALUES_NARROW: v = $signed($urandom_range(16)) - 8;
			VALUES_EDGE: begin
				case ($urandom_range(5))
					0: v = S_MIN;
					1: v = S_MAX;
					2: v = 0;
					3: v = -1;
					4: v = S_MIN + $urandom_range(3);
					default: v = S_MAX - $urandom_range(3);
				endcase
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// results: compare with the oldest expectation
	always @(posedge clk) begin
		median_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_medians.size() == 0) begin
				report_mismatch("unexpected result", longint'(1), longint'(0));
			end else begin
				want = pending_medians.pop_front();
				if ($signed(m_tdata[MEDIAN_W-1:0]) !== want.median2)
					report_mismatch("median_doubled",
						longint'($signed(m_tdata[MEDIAN_W-1:0])),
						longint'(want.median2));
				if (m_tdata[MEDIAN_W +: COUNT_W] !== want.held)
					report_mismatch("count", longint'(m_tdata[MEDIAN_W +: COUNT_W]),
						longint'(want.held));
				if (m_tuser !== want.dropped)
					report_mismatch("full_res", longint'(m_tuser), longint'(want.dropped));
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (stall_asks != stall_seen) begin
			stall_seen = stall_asks;
			stall_left = HOLD_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// extremes of the sum, even and odd counts, duplicates, clears, bit patterns
	task automatic test_directed();
		send_sample(S_MIN, 1);
		send_sample(S_MIN, 0);
		send_sample(S_MAX, 0);
		send_sample(S_MAX, 0);
		send_sample(S_MAX, 0);
		send_sample(S_MAX, 1);
		send_sample(S_MAX, 0);
		send_sample(0, 1);
		send_sample(-1, 0);
		send_sample(1, 0);
		send_sample(5, 0);
		send_sample(1, 0);
		send_sample(1, 0);
		send_sample(32'sh5555_5555, 1);
		send_sample(32'shaaaa_aaaa, 0);
		send_sample(10, 1);
		send_sample(9, 0);
		send_sample(8, 0);
		send_sample(7, 0);
		send_sample(-7, 0);
		send_sample(3, 1);
	endtask

	// fill every slot, overflow a few times, then clear from full
	task automatic test_store_full();
		send_sample(pick_sample(VALUES_WIDE), 1);
		for (int i = 1; i < STORE_DEPTH; i++)
			send_sample(pick_sample(i % 3 == 0 ? VALUES_NARROW : VALUES_WIDE), 0);
		repeat (4) send_sample(pick_sample(VALUES_EDGE), 0);
		send_sample(pick_sample(VALUES_NARROW), 1);
		send_sample(pick_sample(VALUES_NARROW), 0);
	endtask

	// receiver holds off while the sender keeps offering; input must stall
	task automatic test_backpressure();
		stall_asks++;
		send_sample(pick_sample(VALUES_WIDE), 1);
		repeat (39) send_sample(pick_sample(VALUES_WIDE), 0);
	endtask

	// runs of random length, each opened by a clear; a few stray clears mid-run
	task automatic run_random(int n_items);
		int sent;
		int run_len;
		value_mix_t mix;
		sent = 0;
		while (sent < n_items) begin
			run_len = ($urandom_range(99) < 8) ? $urandom_range(200, 300) : $urandom_range(1, 40);
			mix = value_mix_t'($urandom_range(2));
			for (int i = 0; i < run_len && sent < n_items; i++) begin
				send_sample(pick_sample(mix), i == 0 || $urandom_range(99) < 2);
				sent++;
			end
		end
	endtask

	task automatic test_no_idling();
		sender_idle_pct = 0;
		sink_idle_pct = 0;
		run_random(200);
		sender_idle_pct = 22;
		sink_idle_pct = 22;
	endtask

	task automatic test_random_runs();
		run_random(1250);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_store_full();
		test_backpressure();
		test_no_idling();
		test_random_runs();

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_medians.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
design/rm_pkg.sv
design/rm_cell.sv
design/rm_or_tree.sv
design/running_median.sv
tb/testbench.sv
